// File: hdl/gyi_pkg.sv
// ----------------------------------------------------------------------------
// gyi_pkg: shared types and constants for the gyro yaw integrator
// Field widths, opcodes, status codes, sequencer states and the adder
// interface used by the top level and the shared arithmetic unit.
// ----------------------------------------------------------------------------
package gyi_pkg;

    // Fixed-point fraction bits of the rate and bias values
    localparam int FRAC_BITS       = 8;
    localparam int MAX_CAL_SAMPLES = 1023;

    localparam int RAW_W    = 16;
    localparam int US_W     = 20;
    localparam int HEAD_W   = 64;
    localparam int RATE_W   = 24;
    localparam int DEAD_W   = 23;
    localparam int MAXR_W   = 23;
    localparam int SLEW_W   = 24;
    localparam int ANOM_W   = 16;
    localparam int CALN_W   = 10;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 3;

    // bias magnitude stays at or below 2^(RAW_W-1+FRAC_BITS)
    localparam int BIAS_W   = RAW_W + FRAC_BITS + 1;
    // raw_z scaled minus bias
    localparam int RW       = RAW_W + FRAC_BITS + 2;
    // rate minus previous rate
    localparam int DW       = RW + 1;
    localparam int ALU_W    = 64;

    localparam logic [DEAD_W-1:0] DEADBAND_RST = DEAD_W'(10061);
    localparam logic [MAXR_W-1:0] MAX_RATE_RST = MAXR_W'(4024320);
    localparam logic [SLEW_W-1:0] SLEW_RST     = SLEW_W'(2682880);
    localparam logic [ANOM_W-1:0] ANOM_RST     = ANOM_W'(26200);
    localparam logic [CALN_W-1:0] CALN_RST     = CALN_W'(500);

    typedef enum logic [1:0] {
        OP_SAMPLE  = 2'd0,
        OP_CAL     = 2'd1,
        OP_HEADING = 2'd2,
        OP_NONE    = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        STAT_INTEGRATED = 3'd0,
        STAT_CAL_SAMPLE = 3'd1,
        STAT_CAL_DONE   = 3'd2,
        STAT_CAL_FAIL   = 3'd3,
        STAT_HEAD_SET   = 3'd4,
        STAT_CAL_START  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        HOLD_NONE    = 2'd0,
        HOLD_FAILED  = 2'd1,
        HOLD_ANOMALY = 2'd2,
        HOLD_SLEW    = 2'd3
    } hold_t;

    typedef enum logic [2:0] {
        CFG_DEADBAND = 3'd0,
        CFG_MAX_RATE = 3'd1,
        CFG_SLEW     = 3'd2,
        CFG_ANOMALY  = 3'd3,
        CFG_CAL_N    = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RATE,
        ST_DIFF,
        ST_SLEW,
        ST_CLAMP,
        ST_DEAD,
        ST_MUL,
        ST_CSUM,
        ST_CEND,
        ST_CABS,
        ST_CRND,
        ST_CDIV,
        ST_CSIGN,
        ST_OUT
    } state_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             neg;
        logic             zero;
    } alu_res_t;

endpackage

// File: hdl/gyi_alu.sv
// ----------------------------------------------------------------------------
// gyi_alu: shared 64-bit add/subtract unit
// One adder serves every rate, compare, multiply and divide step of the
// sequencer; it also reports sign and zero of the result.
// ----------------------------------------------------------------------------
module gyi_alu (
    input  logic [gyi_pkg::ALU_W-1:0] a,
    input  logic [gyi_pkg::ALU_W-1:0] b,
    input  gyi_pkg::alu_op_t          op,
    output gyi_pkg::alu_res_t         res
);

    logic                      sub;
    logic [gyi_pkg::ALU_W-1:0] b_eff;
    logic [gyi_pkg::ALU_W-1:0] sum;

    assign sub   = (op == gyi_pkg::ALU_SUB);
    assign b_eff = sub ? ~b : b;
    assign sum   = a + b_eff + gyi_pkg::ALU_W'(sub);

    always_comb
    begin
        res.sum  = sum;
        res.neg  = sum[gyi_pkg::ALU_W-1];
        res.zero = (sum == '0);
    end

endmodule

// File: hdl/gyro_yaw_integrator_top.sv
// ----------------------------------------------------------------------------
// gyro_yaw_integrator_top: gyro Z rate filter and heading integrator
// A gyro sample forms the heading product as a shift-add through the shared
//   64-bit adder, one step per significant bit of elapsed_us; a held sample
//   skips clamp and deadband.
// The last calibration sample adds a restoring divide when any read succeeded,
//   one quotient bit per cycle.
// Input is taken only in idle.
// Reset clears heading, rate, bias and calibration state and loads the
//   register defaults; there is no clearing pass.
// ----------------------------------------------------------------------------
module gyro_yaw_integrator_top #(
    parameter int MAX_CAL_SAMPLES = gyi_pkg::MAX_CAL_SAMPLES
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_wr_en,
    input  logic [gyi_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [gyi_pkg::CFG_W-1:0]       cfg_wdata,

    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      opcode,
    input  logic signed [gyi_pkg::RAW_W-1:0] raw_x,
    input  logic signed [gyi_pkg::RAW_W-1:0] raw_y,
    input  logic signed [gyi_pkg::RAW_W-1:0] raw_z,
    input  logic                            read_failed,
    input  logic [gyi_pkg::US_W-1:0]        elapsed_us,
    input  logic signed [gyi_pkg::HEAD_W-1:0] new_heading,

    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [gyi_pkg::HEAD_W-1:0] heading,
    output logic signed [gyi_pkg::RATE_W-1:0] rate_q8,
    output logic [2:0]                      status,
    output logic [1:0]                      hold_reason,
    output logic                            calibrating
);

    localparam int CW     = $clog2(MAX_CAL_SAMPLES + 1);
    localparam int SW     = gyi_pkg::RAW_W + CW;
    localparam int NW     = SW + gyi_pkg::FRAC_BITS;
    localparam int CNT_W  = $clog2(NW);
    localparam int NEED_W = (CW > gyi_pkg::CALN_W) ? CW : gyi_pkg::CALN_W;
    localparam int AW     = gyi_pkg::ALU_W;
    localparam int RW     = gyi_pkg::RW;
    localparam int DW     = gyi_pkg::DW;
    localparam int BW     = gyi_pkg::BIAS_W;
    localparam int RTW    = gyi_pkg::RATE_W;
    localparam int RAWW   = gyi_pkg::RAW_W;
    localparam int USW    = gyi_pkg::US_W;

    // configuration
    logic [gyi_pkg::DEAD_W-1:0] deadband_reg;
    logic [gyi_pkg::MAXR_W-1:0] max_rate_reg;
    logic [gyi_pkg::SLEW_W-1:0] slew_reg;
    logic [gyi_pkg::ANOM_W-1:0] anomaly_reg;
    logic [gyi_pkg::CALN_W-1:0] cal_n_reg;

    // architectural state
    gyi_pkg::state_t            state_reg, state_next;
    logic [gyi_pkg::HEAD_W-1:0] heading_reg;
    logic signed [RTW-1:0]      prev_reg;
    logic signed [BW-1:0]       bias_reg;
    logic signed [SW-1:0]       sum_reg;
    logic [CW-1:0]              valid_reg;
    logic [CW-1:0]              taken_reg;
    logic                       cal_active_reg;

    // working registers
    logic signed [RAWW-1:0]     rz_reg;
    logic                       failed_reg;
    logic [USW-1:0]             us_reg;
    logic signed [RW-1:0]       r_reg;
    logic signed [DW-1:0]       d_reg;
    logic [AW-1:0]              mcand_reg;
    logic [NW-1:0]              num_reg;
    logic [CW-1:0]              rem_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       neg_reg;
    gyi_pkg::status_t           status_reg;
    gyi_pkg::hold_t             hold_reg;

    // output stage
    logic                       out_valid_reg;
    logic [gyi_pkg::HEAD_W-1:0] heading_out_reg;
    logic signed [RTW-1:0]      rate_out_reg;
    gyi_pkg::status_t           status_out_reg;
    gyi_pkg::hold_t             hold_out_reg;
    logic                       cal_out_reg;

    // shared adder
    logic [AW-1:0]              alu_a;
    logic [AW-1:0]              alu_b;
    gyi_pkg::alu_op_t           alu_op;
    gyi_pkg::alu_res_t          alu_res;

    logic                       accept;
    logic                       out_load;
    gyi_pkg::opcode_t           op_in;
    logic [RAWW:0]              x_ext, y_ext, x_mag, y_mag;
    logic                       anomaly;
    logic [NEED_W-1:0]          need;
    logic                       cal_done;
    logic [CW:0]                rem_sh;
    logic [SW-1:0]              sum_mag;
    logic                       dead_zero;
    logic signed [RW-1:0]       r_final;
    logic signed [RW-1:0]       lim_pos;

    gyi_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .op  (alu_op),
        .res (alu_res)
    );

    assign in_ready = (state_reg == gyi_pkg::ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign op_in    = gyi_pkg::opcode_t'(opcode);
    assign out_load = (state_reg == gyi_pkg::ST_OUT) && (!out_valid_reg || out_ready);

    // X/Y anomaly check on the incoming beat
    assign x_ext   = {raw_x[RAWW-1], raw_x};
    assign y_ext   = {raw_y[RAWW-1], raw_y};
    assign x_mag   = x_ext[RAWW] ? ((RAWW+1)'(0) - x_ext) : x_ext;
    assign y_mag   = y_ext[RAWW] ? ((RAWW+1)'(0) - y_ext) : y_ext;
    assign anomaly = (x_mag > (RAWW+1)'(anomaly_reg)) || (y_mag > (RAWW+1)'(anomaly_reg));

    // samples per calibration: zero acts as one, capped at the sample limit
    always_comb
    begin
        need = NEED_W'(cal_n_reg);
        if (need == '0)
        begin
            need = NEED_W'(1);
        end
        else if (need > NEED_W'(MAX_CAL_SAMPLES))
        begin
            need = NEED_W'(MAX_CAL_SAMPLES);
        end
    end

    assign cal_done  = (NEED_W'(taken_reg) >= need);
    assign rem_sh    = {rem_reg, num_reg[NW-1]};
    assign sum_mag   = sum_reg[SW-1] ? alu_res.sum[SW-1:0] : sum_reg;
    assign dead_zero = !alu_res.neg && !alu_res.zero;
    assign r_final   = dead_zero ? '0 : r_reg;
    assign lim_pos   = RW'(max_rate_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gyi_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (op_in)
                        gyi_pkg::OP_SAMPLE:
                            state_next = cal_active_reg ? gyi_pkg::ST_CSUM : gyi_pkg::ST_RATE;
                        gyi_pkg::OP_CAL:     state_next = gyi_pkg::ST_OUT;
                        gyi_pkg::OP_HEADING: state_next = gyi_pkg::ST_OUT;
                        gyi_pkg::OP_NONE:    state_next = gyi_pkg::ST_IDLE;
                    endcase
                end
            end
            gyi_pkg::ST_RATE:  state_next = gyi_pkg::ST_DIFF;
            gyi_pkg::ST_DIFF:  state_next = gyi_pkg::ST_SLEW;
            gyi_pkg::ST_SLEW:
            begin
                if ((hold_reg != gyi_pkg::HOLD_NONE) || alu_res.neg)
                begin
                    state_next = gyi_pkg::ST_MUL;
                end
                else
                begin
                    state_next = gyi_pkg::ST_CLAMP;
                end
            end
            gyi_pkg::ST_CLAMP: state_next = gyi_pkg::ST_DEAD;
            gyi_pkg::ST_DEAD:  state_next = gyi_pkg::ST_MUL;
            gyi_pkg::ST_MUL:
            begin
                if (us_reg[USW-1:1] == '0)
                begin
                    state_next = gyi_pkg::ST_OUT;
                end
            end
            gyi_pkg::ST_CSUM:  state_next = gyi_pkg::ST_CEND;
            gyi_pkg::ST_CEND:
            begin
                if (cal_done && (valid_reg != '0))
                begin
                    state_next = gyi_pkg::ST_CABS;
                end
                else
                begin
                    state_next = gyi_pkg::ST_OUT;
                end
            end
            gyi_pkg::ST_CABS:  state_next = gyi_pkg::ST_CRND;
            gyi_pkg::ST_CRND:  state_next = gyi_pkg::ST_CDIV;
            gyi_pkg::ST_CDIV:
            begin
                if (cnt_reg == CNT_W'(NW - 1))
                begin
                    state_next = gyi_pkg::ST_CSIGN;
                end
            end
            gyi_pkg::ST_CSIGN: state_next = gyi_pkg::ST_OUT;
            gyi_pkg::ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = gyi_pkg::ST_IDLE;
                end
            end
            default:           state_next = gyi_pkg::ST_IDLE;
        endcase
    end

    // adder operands per step
    always_comb
    begin
        alu_a  = '0;
        alu_b  = '0;
        alu_op = gyi_pkg::ALU_ADD;
        unique case (state_reg)
            gyi_pkg::ST_RATE:
            begin
                alu_a  = {{(AW-RAWW){rz_reg[RAWW-1]}}, rz_reg} << gyi_pkg::FRAC_BITS;
                alu_b  = {{(AW-BW){bias_reg[BW-1]}}, bias_reg};
                alu_op = gyi_pkg::ALU_SUB;
            end
            gyi_pkg::ST_DIFF:
            begin
                alu_a  = {{(AW-RW){r_reg[RW-1]}}, r_reg};
                alu_b  = {{(AW-RTW){prev_reg[RTW-1]}}, prev_reg};
                alu_op = gyi_pkg::ALU_SUB;
            end
            // limit minus magnitude: negative value means over the limit
            gyi_pkg::ST_SLEW:
            begin
                alu_a  = AW'(slew_reg);
                alu_b  = {{(AW-DW){d_reg[DW-1]}}, d_reg};
                alu_op = d_reg[DW-1] ? gyi_pkg::ALU_ADD : gyi_pkg::ALU_SUB;
            end
            gyi_pkg::ST_CLAMP:
            begin
                alu_a  = AW'(max_rate_reg);
                alu_b  = {{(AW-RW){r_reg[RW-1]}}, r_reg};
                alu_op = r_reg[RW-1] ? gyi_pkg::ALU_ADD : gyi_pkg::ALU_SUB;
            end
            gyi_pkg::ST_DEAD:
            begin
                alu_a  = AW'(deadband_reg);
                alu_b  = {{(AW-RW){r_reg[RW-1]}}, r_reg};
                alu_op = r_reg[RW-1] ? gyi_pkg::ALU_ADD : gyi_pkg::ALU_SUB;
            end
            gyi_pkg::ST_MUL:
            begin
                alu_a  = heading_reg;
                alu_b  = mcand_reg;
            end
            gyi_pkg::ST_CSUM:
            begin
                alu_a  = {{(AW-SW){sum_reg[SW-1]}}, sum_reg};
                alu_b  = {{(AW-RAWW){rz_reg[RAWW-1]}}, rz_reg};
            end
            gyi_pkg::ST_CABS:
            begin
                alu_b  = {{(AW-SW){sum_reg[SW-1]}}, sum_reg};
                alu_op = gyi_pkg::ALU_SUB;
            end
            // round half away from zero: add half the divisor to the magnitude
            gyi_pkg::ST_CRND:
            begin
                alu_a  = AW'(num_reg);
                alu_b  = AW'(valid_reg >> 1);
            end
            gyi_pkg::ST_CDIV:
            begin
                alu_a  = AW'(rem_sh);
                alu_b  = AW'(valid_reg);
                alu_op = gyi_pkg::ALU_SUB;
            end
            gyi_pkg::ST_CSIGN:
            begin
                alu_b  = AW'(num_reg);
                alu_op = gyi_pkg::ALU_SUB;
            end
            default:
            begin
                alu_a  = '0;
            end
        endcase
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= gyi_pkg::ST_IDLE;
            deadband_reg   <= gyi_pkg::DEADBAND_RST;
            max_rate_reg   <= gyi_pkg::MAX_RATE_RST;
            slew_reg       <= gyi_pkg::SLEW_RST;
            anomaly_reg    <= gyi_pkg::ANOM_RST;
            cal_n_reg      <= gyi_pkg::CALN_RST;
            heading_reg    <= '0;
            prev_reg       <= '0;
            bias_reg       <= '0;
            sum_reg        <= '0;
            valid_reg      <= '0;
            taken_reg      <= '0;
            cal_active_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                unique case (gyi_pkg::cfg_idx_t'(cfg_addr))
                    gyi_pkg::CFG_DEADBAND: deadband_reg <= cfg_wdata[gyi_pkg::DEAD_W-1:0];
                    gyi_pkg::CFG_MAX_RATE: max_rate_reg <= cfg_wdata[gyi_pkg::MAXR_W-1:0];
                    gyi_pkg::CFG_SLEW:     slew_reg     <= cfg_wdata[gyi_pkg::SLEW_W-1:0];
                    gyi_pkg::CFG_ANOMALY:  anomaly_reg  <= cfg_wdata[gyi_pkg::ANOM_W-1:0];
                    gyi_pkg::CFG_CAL_N:    cal_n_reg    <= cfg_wdata[gyi_pkg::CALN_W-1:0];
                    default:               ;
                endcase
            end

            if (accept && (op_in == gyi_pkg::OP_CAL))
            begin
                cal_active_reg <= 1'b1;
                sum_reg        <= '0;
                valid_reg      <= '0;
                taken_reg      <= '0;
            end
            if (accept && (op_in == gyi_pkg::OP_HEADING))
            begin
                heading_reg <= new_heading;
            end

            if (state_reg == gyi_pkg::ST_CSUM)
            begin
                taken_reg <= taken_reg + CW'(1);
                if (!failed_reg)
                begin
                    sum_reg   <= alu_res.sum[SW-1:0];
                    valid_reg <= valid_reg + CW'(1);
                end
            end
            if ((state_reg == gyi_pkg::ST_CEND) && cal_done)
            begin
                cal_active_reg <= 1'b0;
            end
            if (state_reg == gyi_pkg::ST_CSIGN)
            begin
                bias_reg <= neg_reg ? alu_res.sum[BW-1:0] : num_reg[BW-1:0];
            end

            if (state_reg == gyi_pkg::ST_DEAD)
            begin
                prev_reg <= r_final[RTW-1:0];
            end
            if ((state_reg == gyi_pkg::ST_MUL) && us_reg[0])
            begin
                heading_reg <= alu_res.sum;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working and output payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rz_reg     <= raw_z;
            failed_reg <= read_failed;
            us_reg     <= elapsed_us;
            hold_reg   <= gyi_pkg::HOLD_NONE;
            unique case (op_in)
                gyi_pkg::OP_SAMPLE:
                begin
                    if (cal_active_reg)
                    begin
                        status_reg <= gyi_pkg::STAT_CAL_SAMPLE;
                    end
                    else
                    begin
                        status_reg <= gyi_pkg::STAT_INTEGRATED;
                        if (read_failed)
                        begin
                            hold_reg <= gyi_pkg::HOLD_FAILED;
                        end
                        else if (anomaly)
                        begin
                            hold_reg <= gyi_pkg::HOLD_ANOMALY;
                        end
                    end
                end
                gyi_pkg::OP_CAL:     status_reg <= gyi_pkg::STAT_CAL_START;
                gyi_pkg::OP_HEADING: status_reg <= gyi_pkg::STAT_HEAD_SET;
                gyi_pkg::OP_NONE:    status_reg <= status_reg;
            endcase
        end

        unique case (state_reg)
            gyi_pkg::ST_RATE:
            begin
                r_reg <= alu_res.sum[RW-1:0];
            end
            gyi_pkg::ST_DIFF:
            begin
                d_reg <= alu_res.sum[DW-1:0];
            end
            gyi_pkg::ST_SLEW:
            begin
                // held: keep the previous rate, skip clamp and deadband
                mcand_reg <= {{(AW-RTW){prev_reg[RTW-1]}}, prev_reg};
                if ((hold_reg == gyi_pkg::HOLD_NONE) && alu_res.neg)
                begin
                    hold_reg <= gyi_pkg::HOLD_SLEW;
                end
            end
            gyi_pkg::ST_CLAMP:
            begin
                if (alu_res.neg)
                begin
                    r_reg <= r_reg[RW-1] ? -lim_pos : lim_pos;
                end
            end
            gyi_pkg::ST_DEAD:
            begin
                mcand_reg <= {{(AW-RW){r_final[RW-1]}}, r_final};
            end
            gyi_pkg::ST_MUL:
            begin
                mcand_reg <= mcand_reg << 1;
                us_reg    <= us_reg >> 1;
            end
            gyi_pkg::ST_CEND:
            begin
                if (cal_done && (valid_reg == '0))
                begin
                    status_reg <= gyi_pkg::STAT_CAL_FAIL;
                end
                else if (cal_done)
                begin
                    status_reg <= gyi_pkg::STAT_CAL_DONE;
                end
            end
            gyi_pkg::ST_CABS:
            begin
                neg_reg <= sum_reg[SW-1];
                num_reg <= {sum_mag, {gyi_pkg::FRAC_BITS{1'b0}}};
            end
            gyi_pkg::ST_CRND:
            begin
                num_reg <= alu_res.sum[NW-1:0];
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            gyi_pkg::ST_CDIV:
            begin
                // restoring divide, quotient bits shift in behind the dividend
                rem_reg <= alu_res.neg ? rem_sh[CW-1:0] : alu_res.sum[CW-1:0];
                num_reg <= {num_reg[NW-2:0], !alu_res.neg};
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            default:
            begin
                neg_reg <= neg_reg;
            end
        endcase

        if (out_load)
        begin
            heading_out_reg <= heading_reg;
            rate_out_reg    <= prev_reg;
            status_out_reg  <= status_reg;
            hold_out_reg    <= hold_reg;
            cal_out_reg     <= cal_active_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign heading     = heading_out_reg;
    assign rate_q8     = rate_out_reg;
    assign status      = status_out_reg;
    assign hold_reason = hold_out_reg;
    assign calibrating = cal_out_reg;

    // a hold reason only comes with an integrated sample
    a_hold_only_integrated: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (hold_reason != gyi_pkg::HOLD_NONE)
        |-> (status == gyi_pkg::STAT_INTEGRATED))
        else $error("hold reason on a non-integrated beat");

    // calibration end beats report collection stopped
    a_cal_end_inactive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((status == gyi_pkg::STAT_CAL_DONE) || (status == gyi_pkg::STAT_CAL_FAIL))
        |-> !calibrating)
        else $error("calibration end beat with calibrating set");

    // calibration start beats report collection running
    a_cal_start_active: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == gyi_pkg::STAT_CAL_START) |-> calibrating)
        else $error("calibration start beat with calibrating clear");

    // a defined opcode leaves the sequencer busy in the cycle after it is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (opcode != gyi_pkg::OP_NONE) |=> !in_ready)
        else $error("input taken again right after a defined opcode");

endmodule

// File: test/tb_gyro_yaw_integrator_top.sv
// ----------------------------------------------------------------------------
// tb_gyro_yaw_integrator_top: self-checking bench for the gyro yaw integrator
// Feeds gyro samples, calibration starts and heading loads through the
// valid/ready input channel. A local predictor tracks heading, rate, bias
// and calibration state, and every output beat is checked field by field.
// Register settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_gyro_yaw_integrator_top;

    timeunit 1ns;
    timeprecision 1ps;

    import gyi_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int SETTLE_CYCLES   = 48;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLDOFF_AT      = 300;
    localparam int HOLDOFF_CYCLES  = 300;
    localparam int NUM_PHASES      = 10;
    localparam int ITEMS_PER_PHASE = 182;

    typedef struct {
        opcode_t            op;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               fail;
        logic [19:0]        us;
        logic [63:0]        hd;
    } gyro_item_t;

    typedef struct {
        logic [63:0]        heading;
        logic signed [23:0] rate;
        status_t            status;
        hold_t              hold;
        logic               cal;
    } yaw_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]  cfg_wdata = '0;

    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [1:0]        opcode = '0;
    logic signed [15:0] raw_x = '0;
    logic signed [15:0] raw_y = '0;
    logic signed [15:0] raw_z = '0;
    logic              read_failed = 1'b0;
    logic [19:0]       elapsed_us = '0;
    logic signed [63:0] new_heading = '0;

    logic              out_valid;
    logic              out_ready = 1'b0;
    logic signed [63:0] heading;
    logic signed [23:0] rate_q8;
    logic [2:0]        status;
    logic [1:0]        hold_reason;
    logic              calibrating;

    // predictor copy of registers and state
    logic [22:0]        cfg_dead;
    logic [22:0]        cfg_max;
    logic [23:0]        cfg_slew;
    logic [15:0]        cfg_anom;
    logic [9:0]         cfg_cal_n;
    logic [63:0]        head_acc;
    logic signed [23:0] last_rate;
    logic signed [24:0] bias;
    logic signed [25:0] cal_acc;
    logic [9:0]         cal_good;
    logic [9:0]         cal_count;
    logic               cal_on;

    gyro_item_t  gyro_items[$];
    yaw_result_t predicted_outputs[$];
    gyro_item_t  cur_item;
    yaw_result_t pred_res;
    yaw_result_t want_res;

    int unsigned items_pushed = 0;
    int unsigned items_sent = 0;
    int unsigned mismatches = 0;
    int unsigned send_gap = 0;
    int unsigned ready_gap = 0;
    int unsigned holdoff_left = 0;
    int unsigned idle_cycles = 0;
    bit          holdoff_used = 1'b0;
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;

    gyro_yaw_integrator_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .raw_x       (raw_x),
        .raw_y       (raw_y),
        .raw_z       (raw_z),
        .read_failed (read_failed),
        .elapsed_us  (elapsed_us),
        .new_heading (new_heading),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .heading     (heading),
        .rate_q8     (rate_q8),
        .status      (status),
        .hold_reason (hold_reason),
        .calibrating (calibrating)
    );

    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    function automatic longint abs64(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Advance the predicted state by one item; returns 0 when no beat results.
    function automatic bit predict_yaw(input gyro_item_t it, output yaw_result_t res);
        longint rx, ry, rz, prev, r, num, den, q, lim;
        int unsigned need;
        hold_t why;
        status_t st;
        why = HOLD_NONE;
        st = STAT_INTEGRATED;
        if (it.op == OP_NONE)
            return 1'b0;
        rx = longint'(it.x);
        ry = longint'(it.y);
        rz = longint'(it.z);
        if (it.op == OP_CAL) begin
            cal_on = 1'b1;
            cal_acc = '0;
            cal_good = '0;
            cal_count = '0;
            st = STAT_CAL_START;
        end else if (it.op == OP_HEADING) begin
            head_acc = it.hd;
            st = STAT_HEAD_SET;
        end else if (cal_on) begin
            need = (cfg_cal_n == 0) ? 1 : cfg_cal_n;
            if (need > MAX_CAL_SAMPLES)
                need = MAX_CAL_SAMPLES;
            cal_count = cal_count + 1'b1;
            if (!it.fail) begin
                cal_acc = cal_acc + 26'(rz);
                cal_good = cal_good + 1'b1;
            end
            st = STAT_CAL_SAMPLE;
            if (cal_count >= need) begin
                cal_on = 1'b0;
                if (cal_good == 0) begin
                    st = STAT_CAL_FAIL;
                end else begin
                    // round half away from zero
                    num = longint'(cal_acc) * (longint'(1) << FRAC_BITS);
                    den = longint'(cal_good);
                    q = (abs64(num) + den / 2) / den;
                    bias = 25'((num < 0) ? -q : q);
                    st = STAT_CAL_DONE;
                end
            end
        end else begin
            prev = longint'(last_rate);
            r = 0;
            if (it.fail)
                why = HOLD_FAILED;
            else if (abs64(rx) > longint'(cfg_anom) || abs64(ry) > longint'(cfg_anom))
                why = HOLD_ANOMALY;
            else begin
                r = rz * (longint'(1) << FRAC_BITS) - longint'(bias);
                if (abs64(r - prev) > longint'(cfg_slew))
                    why = HOLD_SLEW;
            end
            if (why != HOLD_NONE) begin
                r = prev;
            end else begin
                lim = longint'(cfg_max);
                if (r > lim)
                    r = lim;
                else if (r < -lim)
                    r = -lim;
                if (abs64(r) < longint'(cfg_dead))
                    r = 0;
            end
            last_rate = r[23:0];
            head_acc = head_acc + r * longint'({44'd0, it.us});
        end
        res.heading = head_acc;
        res.rate = last_rate;
        res.status = st;
        res.hold = why;
        res.cal = cal_on;
        return 1'b1;
    endfunction

    function automatic int unsigned pick_gap(inout bit calm);
        int unsigned roll;
        if ($urandom_range(0, 99) < 2)
            calm = !calm;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic gyro_item_t make_item(opcode_t op, int x, int y, int z,
                                             bit fail, int unsigned us, logic [63:0] hd);
        gyro_item_t it;
        it.op = op;
        it.x = 16'(x);
        it.y = 16'(y);
        it.z = 16'(z);
        it.fail = fail;
        it.us = 20'(us);
        it.hd = hd;
        return it;
    endfunction

    function automatic int rand_raw();
        case ($urandom_range(0, 9))
            0: return -32768;
            1: return 32767;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    // X/Y mostly inside the anomaly window, with its edges and outliers
    function automatic int rand_axis();
        int lim;
        int v;
        lim = int'(cfg_anom);
        case ($urandom_range(0, 19))
            0: v = lim + 1;
            1: v = -lim - 1;
            2: v = lim;
            3: v = -lim;
            4: v = rand_raw();
            default: v = int'($urandom_range(0, 2 * lim)) - lim;
        endcase
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v;
    endfunction

    function automatic int drift_z(int zc);
        int v;
        v = zc + int'($urandom_range(0, 4000)) - 2000;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v;
    endfunction

    function automatic int unsigned rand_us();
        case ($urandom_range(0, 19))
            0: return 0;
            1: return 20'hFFFFF;
            2: return 1 << $urandom_range(0, 19);
            3, 4: return $urandom_range(0, 20'hFFFFF);
            default: return $urandom_range(1, 4000);
        endcase
    endfunction

    function automatic logic [63:0] rand_head();
        case ($urandom_range(0, 9))
            0: return 64'h7FFF_FFFF_FFFF_FFFF;
            1: return 64'h8000_0000_0000_0000;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic push_item(gyro_item_t it);
        gyro_items.push_back(it);
        items_pushed++;
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [23:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_DEADBAND: cfg_dead = val[22:0];
            CFG_MAX_RATE: cfg_max = val[22:0];
            CFG_SLEW:     cfg_slew = val[23:0];
            CFG_ANOMALY:  cfg_anom = val[15:0];
            CFG_CAL_N:    cfg_cal_n = val[9:0];
            default: ;
        endcase
    endtask

    task automatic set_config(int unsigned dead, int unsigned maxr, int unsigned slew,
                              int unsigned anom, int unsigned caln);
        write_reg(CFG_DEADBAND, 24'(dead));
        write_reg(CFG_MAX_RATE, 24'(maxr));
        write_reg(CFG_SLEW, 24'(slew));
        write_reg(CFG_ANOMALY, 24'(anom));
        write_reg(CFG_CAL_N, 24'(caln));
    endtask

    task automatic wait_idle();
        while (!(items_sent == items_pushed && predicted_outputs.size() == 0))
            @(posedge clk);
        // let an ignored opcode drain before touching registers
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_directed();
        push_item(make_item(OP_SAMPLE, 0, 0, 0, 0, 0, 0));
        push_item(make_item(OP_SAMPLE, 0, 0, 100, 0, 1000, 0));
        // inside the deadband
        push_item(make_item(OP_SAMPLE, 0, 0, 10, 0, 1, 0));
        // read failure wins over an X/Y anomaly
        push_item(make_item(OP_SAMPLE, 32767, -32768, 32767, 1, 20, 0));
        push_item(make_item(OP_SAMPLE, -32768, 0, 50, 0, 30, 0));
        push_item(make_item(OP_SAMPLE, 0, 26201, 50, 0, 30, 0));
        push_item(make_item(OP_SAMPLE, 26200, -26200, 50, 0, 100, 0));
        push_item(make_item(OP_SAMPLE, 0, 0, 32767, 0, 100, 0));
        push_item(make_item(OP_SAMPLE, 0, 0, -32768, 0, 100, 0));
        // ramp up into the positive clamp, then down into the negative one
        push_item(make_item(OP_SAMPLE, 0, 0, 10000, 0, 20'hFFFFF, 0));
        push_item(make_item(OP_SAMPLE, 0, 0, 20000, 0, 20'hFFFFF, 0));
        push_item(make_item(OP_SAMPLE, 0, 0, 6000, 0, 500, 0));
        push_item(make_item(OP_SAMPLE, 0, 0, -4000, 0, 500, 0));
        push_item(make_item(OP_SAMPLE, 0, 0, -14000, 0, 500, 0));
        push_item(make_item(OP_HEADING, 0, 0, 0, 0, 0, 64'h8000_0000_0000_0010));
        // heading wraps through the negative end
        push_item(make_item(OP_SAMPLE, 0, 0, -24000, 0, 20'hFFFFF, 0));
        push_item(make_item(OP_NONE, -1, -1, -1, 1, 20'hFFFFF, '1));
        push_item(make_item(OP_HEADING, 0, 0, 0, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF));
        // calibration with every read failed keeps the bias
        push_item(make_item(OP_CAL, 0, 0, 0, 0, 0, 0));
        push_item(make_item(OP_SAMPLE, 0, 0, 1234, 1, 10, 0));
        push_item(make_item(OP_SAMPLE, 0, 0, 1234, 1, 10, 0));
        // heading load mid-calibration, then restart
        push_item(make_item(OP_CAL, 0, 0, 0, 0, 0, 0));
        push_item(make_item(OP_SAMPLE, 0, 0, -7, 0, 10, 0));
        push_item(make_item(OP_HEADING, 0, 0, 0, 0, 0, 0));
        push_item(make_item(OP_CAL, 0, 0, 0, 0, 0, 0));
        push_item(make_item(OP_SAMPLE, 0, 0, -3, 0, 10, 0));
        push_item(make_item(OP_SAMPLE, 0, 0, -4, 0, 10, 0));
        push_item(make_item(OP_SAMPLE, 0, 0, 0, 0, 500, 0));
    endtask

    task automatic gen_phase(int unsigned n);
        int unsigned made;
        int unsigned roll;
        int unsigned k;
        int zc;
        int zcal;
        made = 0;
        zc = int'($urandom_range(0, 4000)) - 2000;
        while (made < n) begin
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
                push_item(make_item(OP_CAL, rand_raw(), rand_raw(), rand_raw(),
                                    $urandom_range(0, 1), rand_us(), rand_head()));
                made++;
                k = (cfg_cal_n == 0) ? 1 : cfg_cal_n;
                if (k > 24)
                    k = $urandom_range(4, 24);
                else if ($urandom_range(0, 3) == 0)
                    k = $urandom_range(0, k);
                zcal = rand_raw();
                for (int i = 0; i < k; i++) begin
                    if ($urandom_range(0, 29) == 0)
                        push_item(make_item(OP_HEADING, rand_raw(), rand_raw(), rand_raw(),
                                            $urandom_range(0, 1), rand_us(), rand_head()));
                    else
                        push_item(make_item(OP_SAMPLE, rand_axis(), rand_axis(),
                                            drift_z(zcal), $urandom_range(0, 9) == 0,
                                            rand_us(), rand_head()));
                    made++;
                end
            end else if (roll < 16) begin
                push_item(make_item(OP_HEADING, rand_raw(), rand_raw(), rand_raw(),
                                    $urandom_range(0, 1), rand_us(), rand_head()));
                made++;
            end else if (roll < 19) begin
                push_item(make_item(OP_NONE, rand_raw(), rand_raw(), rand_raw(),
                                    $urandom_range(0, 1), rand_us(), rand_head()));
            end else begin
                repeat ($urandom_range(1, 12)) begin
                    if ($urandom_range(0, 9) == 0)
                        zc = rand_raw();
                    else
                        zc = drift_z(zc);
                    push_item(make_item(OP_SAMPLE, rand_axis(), rand_axis(), zc,
                                        $urandom_range(0, 19) == 0, rand_us(), rand_head()));
                    made++;
                end
            end
        end
    endtask

    // input driver: one beat at a time from the pending list
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (in_valid && in_ready) begin
                if (predict_yaw(cur_item, pred_res))
                    predicted_outputs.push_back(pred_res);
                items_sent++;
                send_gap = pick_gap(tx_calm);
            end
            if (!in_valid || in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (gyro_items.size() > 0) begin
                    cur_item = gyro_items.pop_front();
                    opcode <= cur_item.op;
                    raw_x <= cur_item.x;
                    raw_y <= cur_item.y;
                    raw_z <= cur_item.z;
                    read_failed <= cur_item.fail;
                    elapsed_us <= cur_item.us;
                    new_heading <= cur_item.hd;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output ready: random stalls plus one long hold-off to back up the input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (holdoff_left > 0) begin
            holdoff_left--;
            out_ready <= 1'b0;
        end else if (!holdoff_used && items_sent >= HOLDOFF_AT) begin
            holdoff_used = 1'b1;
            holdoff_left = HOLDOFF_CYCLES;
            out_ready <= 1'b0;
        end else if (ready_gap > 0) begin
            ready_gap--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
            ready_gap = pick_gap(rx_calm);
        end
    end

    task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %0h, got %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) begin
            if (predicted_outputs.size() == 0) begin
                $display("%0t ns: output beat with no prediction pending, heading %0h",
                         $time, heading);
                mismatches++;
            end else begin
                want_res = predicted_outputs.pop_front();
                check_field("heading", want_res.heading, heading);
                check_field("rate_q8", want_res.rate, rate_q8);
                check_field("status", want_res.status, status);
                check_field("hold_reason", want_res.hold, hold_reason);
                check_field("calibrating", want_res.cal, calibrating);
            end
        end
    end

    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t ns: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        cfg_dead = DEADBAND_RST;
        cfg_max = MAX_RATE_RST;
        cfg_slew = SLEW_RST;
        cfg_anom = ANOM_RST;
        cfg_cal_n = CALN_RST;
        head_acc = '0;
        last_rate = '0;
        bias = '0;
        cal_acc = '0;
        cal_good = '0;
        cal_count = '0;
        cal_on = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        write_reg(CFG_CAL_N, 24'd2);
        load_directed();
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: set_config(10061, 4024320, 2682880, 26200, 6);
                1: set_config(0, 23'h7FFFFF, 24'hFFFFFF, 32768, 0);
                2: set_config(23'h7FFFFF, 0, 0, 0, 1);
                3: set_config(10061, 4024320, 2682880, 26200, 1023);
                // a calibration left open above ends on the first sample here
                4: set_config(5000, 3000000, 2000000, 20000, 4);
                default: set_config($urandom_range(0, 20000), $urandom_range(100000, 23'h7FFFFF),
                                    $urandom_range(200000, 5000000),
                                    $urandom_range(1000, 32768), $urandom_range(1, 12));
            endcase
            gen_phase(ITEMS_PER_PHASE);
            wait_idle();
        end

        if (mismatches == 0 && predicted_outputs.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
